// ===== hw/rtl/fsf_pkg.sv =====
package fsf_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_SYMBOLS = 16;
    localparam int DEF_COUNT_BITS  = 32;

    // Stream bytes that steer the parser
    localparam int DATA_W = 8;
    localparam logic [DATA_W-1:0] BYTE_NL = 8'h0A;
    localparam logic [DATA_W-1:0] BYTE_GT = 8'h3E;

    // Configuration registers
    localparam int CFG_IDX_W = 2;
    localparam int ALPHA_W   = 64;
    localparam int SIZE_W    = 5;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_HI = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE     = 2'd2;
    localparam logic [SIZE_W-1:0]    SIZE_RESET   = 5'd4;

    // Result fields
    localparam int SYM_IDX_W  = 4;
    localparam int FRAC_BITS  = 16;
    localparam int ITER_W     = $clog2(FRAC_BITS);
    localparam int FREQ_W     = FRAC_BITS + 1;
    localparam int OUT_DATA_W = ((SYM_IDX_W + FREQ_W + 7) / 8) * 8;
    localparam logic [FREQ_W-1:0] FREQ_ONE = FREQ_W'(1) << FRAC_BITS;

endpackage

// ===== hw/rtl/fasta_symbol_frequency_unit.sv =====
// FASTA symbol composition unit.
// Input beats arrive on s_tvalid/s_tready: s_tdata carries one stream byte,
// s_tuser carries the end-of-stream flag. Header lines and sequence lines are
// told apart by newline and '>' bytes; every sequence byte that matches the
// configured alphabet bumps that symbol's counter and the read length.
// At the end of each header line that follows a read, and at end of stream,
// one row of results leaves on m_tvalid/m_tready: one beat per symbol in
// alphabet order, m_tlast on the final one, m_tuser set when the read was empty.
// The alphabet is written through cfg_valid/cfg_ready/cfg_index/cfg_data.
// Throughput: one byte per cycle while counting. The counters sit in a
// one-port-read memory with a registered read; a same-symbol byte in the
// next cycle is forwarded around the write. Per symbol, a row runs a memory
// read, a load, up to 16 restoring-division steps and the output, during
// which s_tready is low; the last result may still wait in the output
// register while new bytes are taken. If the receiver stalls, the row simply
// waits in the output state. Reset returns to header mode with all counts
// cleared at once (per-entry valid bits) and the alphabet at its reset value.
module fasta_symbol_frequency_unit #(
    parameter int MAX_SYMBOLS = fsf_pkg::DEF_MAX_SYMBOLS,
    parameter int COUNT_BITS  = fsf_pkg::DEF_COUNT_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [fsf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fsf_pkg::ALPHA_W-1:0]      cfg_data,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [fsf_pkg::DATA_W-1:0]       s_tdata,   // [7:0] data_byte
    input  logic [0:0]                       s_tuser,   // [0] end_of_stream
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [fsf_pkg::OUT_DATA_W-1:0]   m_tdata,   // [3:0] symbol_index,
                                                        // [20:4] frequency
    output logic [0:0]                       m_tuser,   // [0] empty_read
    output logic                             m_tlast    // last
);

    import fsf_pkg::*;

    localparam int IDX_W = $clog2(MAX_SYMBOLS);
    localparam int PAD_W = OUT_DATA_W - SYM_IDX_W - FREQ_W;

    localparam logic [2:0] ST_RUN  = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_LOAD = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    // configuration
    logic [ALPHA_W-1:0]     alpha_lo_reg;
    logic [ALPHA_W-1:0]     alpha_hi_reg;
    logic [SIZE_W-1:0]      alpha_size_reg;
    logic [SIZE_W-1:0]      eff_size;
    logic [2*ALPHA_W-1:0]   alphabet;

    // parser and control state
    logic [2:0]             state_reg;
    logic                   in_header_reg;
    logic                   read_seen_reg;
    logic [COUNT_BITS-1:0]  read_length_reg;
    logic [MAX_SYMBOLS-1:0] cnt_vld_reg;

    // counter memory
    logic [COUNT_BITS-1:0]  cnt_mem [MAX_SYMBOLS];
    logic [COUNT_BITS-1:0]  rdata_reg;
    logic [IDX_W-1:0]       rd_addr;

    // read-modify-write stage
    logic                   p1_valid_reg;
    logic [IDX_W-1:0]       p1_idx_reg;
    logic                   wr_valid_reg;
    logic [IDX_W-1:0]       wr_idx_reg;
    logic [COUNT_BITS-1:0]  wr_data_reg;
    logic [IDX_W-1:0]       cur_idx;
    logic [COUNT_BITS-1:0]  count_cur;
    logic [COUNT_BITS-1:0]  count_inc;

    // byte decode
    logic                   in_fire;
    logic                   eos;
    logic [DATA_W-1:0]      in_byte;
    logic                   is_gt;
    logic                   hdr_mode;
    logic                   hit;
    logic [IDX_W-1:0]       hit_idx;
    logic                   row_start;

    // row emission and divider
    logic [IDX_W-1:0]       emit_idx_reg;
    logic [COUNT_BITS-1:0]  len_snap_reg;
    logic [COUNT_BITS-1:0]  rem_reg;
    logic [FRAC_BITS-1:0]   quo_reg;
    logic [ITER_W-1:0]      iter_reg;
    logic [FREQ_W-1:0]      res_freq_reg;
    logic                   res_empty_reg;
    logic [COUNT_BITS:0]    rem_sh;
    logic                   div_ge;
    logic [COUNT_BITS-1:0]  rem_next;
    logic [FRAC_BITS-1:0]   quo_next;
    logic                   emit_last;
    logic                   out_free;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_RUN);
    assign in_fire   = s_tvalid && s_tready;
    assign eos       = s_tuser[0];
    assign in_byte   = s_tdata;
    assign out_free  = !m_tvalid || m_tready;

    // Clamp the alphabet size to the counter depth
    assign eff_size = (alpha_size_reg > SIZE_W'(MAX_SYMBOLS)) ? SIZE_W'(MAX_SYMBOLS)
                                                             : alpha_size_reg;
    assign alphabet = {alpha_hi_reg, alpha_lo_reg};

    // Find the lowest alphabet position that matches the byte
    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = MAX_SYMBOLS - 1; i >= 0; i--)
        begin
            if ((alphabet[i*DATA_W +: DATA_W] == in_byte) && (SIZE_W'(i) < eff_size))
            begin
                hit     = 1'b1;
                hit_idx = IDX_W'(i);
            end
        end
    end

    assign is_gt     = !in_header_reg && (in_byte == BYTE_GT);
    assign hdr_mode  = in_header_reg || is_gt;
    // A row follows end of stream, or a header newline after a read
    assign row_start = in_fire && (eos || (in_header_reg && (in_byte == BYTE_NL)
                                           && read_seen_reg));

    // Counter value: forward last cycle's write, unwritten entries read zero
    assign cur_idx   = (state_reg == ST_RUN) ? p1_idx_reg : emit_idx_reg;
    assign count_cur = (wr_valid_reg && (wr_idx_reg == cur_idx)) ? wr_data_reg :
                       (cnt_vld_reg[cur_idx] ? rdata_reg : '0);
    assign count_inc = (count_cur == '1) ? count_cur : count_cur + 1'b1;

    assign rd_addr   = (state_reg == ST_RUN) ? hit_idx : emit_idx_reg;

    // One restoring-division step
    assign rem_sh   = {rem_reg, 1'b0};
    assign div_ge   = rem_sh >= {1'b0, len_snap_reg};
    assign rem_next = div_ge ? COUNT_BITS'(rem_sh - {1'b0, len_snap_reg})
                             : rem_sh[COUNT_BITS-1:0];
    assign quo_next = {quo_reg[FRAC_BITS-2:0], div_ge};

    assign emit_last = ((SIZE_W'(emit_idx_reg) + SIZE_W'(1)) == eff_size);

    // Counter memory: write back, registered read
    always_ff @(posedge clk)
    begin
        if (p1_valid_reg)
        begin
            cnt_mem[p1_idx_reg] <= count_inc;
        end
        rdata_reg <= cnt_mem[rd_addr];
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_lo_reg   <= '0;
            alpha_hi_reg   <= '0;
            alpha_size_reg <= SIZE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ALPHA_LO: alpha_lo_reg   <= cfg_data;
                REG_ALPHA_HI: alpha_hi_reg   <= cfg_data;
                REG_SIZE:     alpha_size_reg <= cfg_data[SIZE_W-1:0];
                default:      ;
            endcase
        end
    end

    // Write-back stage payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            p1_idx_reg <= hit_idx;
        end
        wr_idx_reg  <= p1_idx_reg;
        wr_data_reg <= count_inc;
    end

    // Parser, counter valid bits and row sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_RUN;
            in_header_reg   <= 1'b1;
            read_seen_reg   <= 1'b0;
            read_length_reg <= '0;
            cnt_vld_reg     <= '0;
            p1_valid_reg    <= 1'b0;
            wr_valid_reg    <= 1'b0;
            emit_idx_reg    <= '0;
            iter_reg        <= '0;
            m_tvalid        <= 1'b0;
        end
        else
        begin
            wr_valid_reg <= p1_valid_reg;
            p1_valid_reg <= 1'b0;
            if (p1_valid_reg)
            begin
                cnt_vld_reg[p1_idx_reg] <= 1'b1;
            end
            // drop the result once taken
            if (m_tvalid && m_tready)
            begin
                m_tvalid <= 1'b0;
            end

            case (state_reg)
                ST_RUN:
                begin
                    if (in_fire)
                    begin
                        if (eos)
                        begin
                            in_header_reg   <= 1'b1;
                            read_seen_reg   <= 1'b0;
                            read_length_reg <= '0;
                        end
                        else if (is_gt)
                        begin
                            read_seen_reg <= 1'b1;
                            in_header_reg <= 1'b1;
                        end
                        else if (hdr_mode)
                        begin
                            if (in_byte == BYTE_NL)
                            begin
                                in_header_reg   <= 1'b0;
                                read_length_reg <= '0;
                            end
                        end
                        else if (hit)
                        begin
                            p1_valid_reg <= 1'b1;
                            if (read_length_reg != '1)
                            begin
                                read_length_reg <= read_length_reg + 1'b1;
                            end
                        end

                        if (row_start)
                        begin
                            if (eff_size != '0)
                            begin
                                emit_idx_reg <= '0;
                                state_reg    <= ST_READ;
                            end
                            else
                            begin
                                cnt_vld_reg <= '0;
                            end
                        end
                    end
                end

                ST_READ:
                begin
                    state_reg <= ST_LOAD;
                end

                ST_LOAD:
                begin
                    iter_reg <= '0;
                    if ((len_snap_reg == '0) || (count_cur >= len_snap_reg))
                    begin
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        state_reg <= ST_DIV;
                    end
                end

                ST_DIV:
                begin
                    iter_reg <= iter_reg + 1'b1;
                    if (iter_reg == ITER_W'(FRAC_BITS - 1))
                    begin
                        state_reg <= ST_OUT;
                    end
                end

                ST_OUT:
                begin
                    if (out_free)
                    begin
                        m_tvalid <= 1'b1;
                        if (emit_last)
                        begin
                            cnt_vld_reg <= '0;
                            state_reg   <= ST_RUN;
                        end
                        else
                        begin
                            emit_idx_reg <= emit_idx_reg + 1'b1;
                            state_reg    <= ST_READ;
                        end
                    end
                end

                default:
                begin
                    state_reg <= ST_RUN;
                end
            endcase
        end
    end

    // Row datapath: length snapshot, divider, result and output registers
    always_ff @(posedge clk)
    begin
        if (row_start)
        begin
            len_snap_reg <= read_length_reg;
        end

        if (state_reg == ST_LOAD)
        begin
            rem_reg <= count_cur;
            quo_reg <= '0;
            if (len_snap_reg == '0)
            begin
                res_freq_reg  <= '0;
                res_empty_reg <= 1'b1;
            end
            else
            begin
                res_freq_reg  <= FREQ_ONE;
                res_empty_reg <= 1'b0;
            end
        end

        if (state_reg == ST_DIV)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            if (iter_reg == ITER_W'(FRAC_BITS - 1))
            begin
                res_freq_reg <= FREQ_W'(quo_next);
            end
        end

        if ((state_reg == ST_OUT) && out_free)
        begin
            m_tdata <= {{PAD_W{1'b0}}, res_freq_reg, SYM_IDX_W'(emit_idx_reg)};
            m_tuser <= res_empty_reg;
            m_tlast <= emit_last;
        end
    end

endmodule
